/* hw/rtl/dmt_pkg.sv */
package dmt_pkg;

    localparam int POS_W           = 11;
    localparam int VAL_W           = 32;
    localparam int MEX_W           = 11;
    localparam int CFG_W           = 11;
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int WORD_W          = 32;
    localparam int BIT_W           = 5;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

    // Separate write enables for the two fields of a row.
    typedef struct packed {
        logic val_we;
        logic cnt_we;
    } ent_we_t;

endpackage

/* hw/rtl/dynamic_mex_tracker.sv */
// A request with a position in range passes through S_OLD, S_DROP, S_ADD, S_FIND and
// S_PICK; a position of zero or beyond the size in use goes straight to S_FIND and S_PICK.
// A new request is taken only once the last one's mex is loaded for output, a limit set by the
// read-modify-write of the count row memory and the presence word memory.
// Reset is asynchronous; afterwards a clearing pass over every count row and presence word
// initializes both memories while in_stall stays high.
module dynamic_mex_tracker #(
    parameter int MAX_ENTRIES = dmt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [dmt_pkg::POS_W-1:0] position,
    input  logic [dmt_pkg::VAL_W-1:0] new_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [dmt_pkg::MEX_W-1:0] mex,
    input  logic                      cfg_wr_en,
    input  logic [dmt_pkg::CFG_W-1:0] cfg_wr_data
);
    import dmt_pkg::*;

    localparam int ROWS  = MAX_ENTRIES + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int PW    = (MAX_ENTRIES + 2 + WORD_W - 1) / WORD_W;
    localparam int WAW   = (PW > 1) ? $clog2(PW) : 1;
    localparam int IW    = WAW + BIT_W;
    localparam int CLR_N = PW * WORD_W;

    localparam logic [VAL_W-1:0] MAX_V    = VAL_W'(MAX_ENTRIES);
    localparam logic [IW-1:0]    MAX_I    = IW'(MAX_ENTRIES);
    localparam logic [IW-1:0]    CLR_LAST = IW'(CLR_N - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_OLD   = 7'b0000100,
        S_DROP  = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_FIND  = 7'b0100000,
        S_PICK  = 7'b1000000
    } state_t;

    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [IW-1:0]      clr_reg;
    logic [CFG_W-1:0]   entries_reg;
    logic [RW-1:0]      slot_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [IW-1:0]      vidx_reg;
    logic               add_ok_reg;
    logic [IW-1:0]      oidx_reg;
    logic               drop_ok_reg;
    logic [CW-1:0]      dcnt_reg;
    logic [WORD_W-1:0]  dword_reg;
    logic [WAW-1:0]     widx_reg;
    logic               out_valid_reg;
    logic [MEX_W-1:0]   mex_reg;

    logic [CFG_W-1:0]   limit;
    logic [POS_W-1:0]   pos_m1;
    logic               pos_ok;
    logic [IW-1:0]      old_idx;
    logic               old_ok;
    logic [CW-1:0]      drop_cnt;
    logic [WORD_W-1:0]  drop_word;
    logic [CW-1:0]      base_cnt;
    logic [WORD_W-1:0]  base_word;
    logic [IW-1:0]      zero_idx;
    logic [MEX_W-1:0]   mex_val;
    logic               load_out;

    logic [RW-1:0]      e_rd_addr;
    logic [VAL_W-1:0]   e_rd_val;
    logic [CW-1:0]      e_rd_cnt;
    ent_we_t            e_we;
    logic [RW-1:0]      e_wr_addr;
    logic [VAL_W-1:0]   e_wr_val;
    logic [CW-1:0]      e_wr_cnt;

    logic [WAW-1:0]     p_rd_addr;
    logic [WORD_W-1:0]  p_rd_data;
    logic               p_wr_en;
    logic [WAW-1:0]     p_wr_addr;
    logic [WORD_W-1:0]  p_wr_data;
    logic [WAW-1:0]     p_open;

    dmt_entry_mem #(
        .ROWS (ROWS),
        .RW   (RW),
        .CW   (CW)
    ) u_entry_mem (
        .clk     (clk),
        .rd_addr (e_rd_addr),
        .rd_val  (e_rd_val),
        .rd_cnt  (e_rd_cnt),
        .we      (e_we),
        .wr_addr (e_wr_addr),
        .wr_val  (e_wr_val),
        .wr_cnt  (e_wr_cnt)
    );

    dmt_pres_mem #(
        .PW  (PW),
        .WAW (WAW)
    ) u_pres_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (p_rd_addr),
        .rd_data  (p_rd_data),
        .wr_en    (p_wr_en),
        .wr_addr  (p_wr_addr),
        .wr_data  (p_wr_data),
        .open_idx (p_open)
    );

    // A register setting above the capacity acts as the capacity.
    assign limit   = (VAL_W'(entries_reg) > MAX_V) ? MAX_V[CFG_W-1:0] : entries_reg;
    assign pos_m1  = position - POS_W'(1);
    assign pos_ok  = (position != '0) && (position <= limit);
    assign old_idx = IW'(e_rd_val);
    assign old_ok  = (e_rd_val <= MAX_V);

    assign drop_cnt = (e_rd_cnt != '0) ? e_rd_cnt - CW'(1) : '0;

    always_comb
    begin
        drop_word = p_rd_data;
        drop_word[oidx_reg[BIT_W-1:0]] = (drop_cnt != '0);
    end

    // The drop step may have just written the same count or word that the add step reads.
    assign base_cnt  = (drop_ok_reg && (oidx_reg == vidx_reg)) ? dcnt_reg : e_rd_cnt;
    assign base_word = (drop_ok_reg && (oidx_reg[IW-1:BIT_W] == vidx_reg[IW-1:BIT_W]))
                       ? dword_reg : p_rd_data;

    assign zero_idx = {widx_reg, first_zero(p_rd_data)};
    assign mex_val  = (VAL_W'(zero_idx) > VAL_W'(limit)) ? MEX_W'(limit + CFG_W'(1))
                                                          : MEX_W'(zero_idx);
    assign load_out = (state_reg == S_PICK) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        e_rd_addr  = slot_reg;
        e_we       = '0;
        e_wr_addr  = slot_reg;
        e_wr_val   = val_reg;
        e_wr_cnt   = '0;
        p_rd_addr  = widx_reg;
        p_wr_en    = 1'b0;
        p_wr_addr  = vidx_reg[IW-1:BIT_W];
        p_wr_data  = '0;
        case (state_reg)
            S_CLEAR:
            begin
                e_we.val_we = (clr_reg <= MAX_I);
                e_we.cnt_we = (clr_reg <= MAX_I);
                e_wr_addr   = RW'(clr_reg);
                e_wr_val    = '1;
                p_wr_en     = 1'b1;
                p_wr_addr   = clr_reg[IW-1:BIT_W];
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                e_rd_addr = RW'(pos_m1);
                if (in_valid)
                begin
                    state_next = pos_ok ? S_OLD : S_FIND;
                end
            end
            S_OLD:
            begin
                e_we.val_we = 1'b1;
                e_rd_addr   = old_idx[RW-1:0];
                p_rd_addr   = old_idx[IW-1:BIT_W];
                state_next  = S_DROP;
            end
            S_DROP:
            begin
                e_we.cnt_we = drop_ok_reg;
                e_wr_addr   = oidx_reg[RW-1:0];
                e_wr_cnt    = drop_cnt;
                p_wr_en     = drop_ok_reg;
                p_wr_addr   = oidx_reg[IW-1:BIT_W];
                p_wr_data   = drop_word;
                e_rd_addr   = vidx_reg[RW-1:0];
                p_rd_addr   = vidx_reg[IW-1:BIT_W];
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                e_we.cnt_we = add_ok_reg;
                e_wr_addr   = vidx_reg[RW-1:0];
                e_wr_cnt    = base_cnt + CW'(1);
                p_wr_en     = add_ok_reg;
                p_wr_data   = base_word;
                p_wr_data[vidx_reg[BIT_W-1:0]] = 1'b1;
                state_next  = S_FIND;
            end
            S_FIND:
            begin
                p_rd_addr  = p_open;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            entries_reg   <= ENTRIES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + IW'(1);
            end
            if (cfg_wr_en)
            begin
                entries_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            slot_reg   <= RW'(pos_m1);
            val_reg    <= new_value;
            vidx_reg   <= IW'(new_value);
            add_ok_reg <= (new_value <= MAX_V);
        end
        if (state_reg == S_OLD)
        begin
            oidx_reg    <= old_idx;
            drop_ok_reg <= old_ok;
        end
        if (state_reg == S_DROP)
        begin
            dcnt_reg  <= drop_cnt;
            dword_reg <= drop_word;
        end
        if (state_reg == S_FIND)
        begin
            widx_reg <= p_open;
        end
        if (load_out)
        begin
            mex_reg <= mex_val;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign mex       = mex_reg;

endmodule

/* hw/rtl/dmt_entry_mem.sv */
module dmt_entry_mem #(
    parameter int ROWS = dmt_pkg::MAX_ENTRIES_DEF + 1,
    parameter int RW   = 11,
    parameter int CW   = 11
) (
    input  logic                      clk,
    input  logic [RW-1:0]             rd_addr,
    output logic [dmt_pkg::VAL_W-1:0] rd_val,
    output logic [CW-1:0]             rd_cnt,
    input  dmt_pkg::ent_we_t          we,
    input  logic [RW-1:0]             wr_addr,
    input  logic [dmt_pkg::VAL_W-1:0] wr_val,
    input  logic [CW-1:0]             wr_cnt
);
    import dmt_pkg::*;

    // Row v holds the stored value of position v + 1 and the count of value v.
    logic [VAL_W-1:0] mem_val [ROWS];
    logic [CW-1:0]    mem_cnt [ROWS];
    logic [VAL_W-1:0] rd_val_reg;
    logic [CW-1:0]    rd_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (we.val_we)
        begin
            mem_val[wr_addr] <= wr_val;
        end
        if (we.cnt_we)
        begin
            mem_cnt[wr_addr] <= wr_cnt;
        end
        rd_val_reg <= mem_val[rd_addr];
        rd_cnt_reg <= mem_cnt[rd_addr];
    end

    assign rd_val = rd_val_reg;
    assign rd_cnt = rd_cnt_reg;

endmodule

/* hw/rtl/dmt_pres_mem.sv */
module dmt_pres_mem #(
    parameter int PW  = 33,
    parameter int WAW = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [WAW-1:0]             rd_addr,
    output logic [dmt_pkg::WORD_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [WAW-1:0]             wr_addr,
    input  logic [dmt_pkg::WORD_W-1:0] wr_data,
    output logic [WAW-1:0]             open_idx
);
    import dmt_pkg::*;

    logic [WORD_W-1:0] mem [PW];
    logic [WORD_W-1:0] rd_data_reg;
    logic [PW-1:0]     full_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // One flag per word, set while every bit of the word is present.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (wr_en)
        begin
            full_reg[wr_addr] <= &wr_data;
        end
    end

    always_comb
    begin
        open_idx = '0;
        for (int i = PW - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                open_idx = WAW'(i);
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/dmt_checker.sv */
module dmt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [dmt_pkg::MEX_W-1:0] mex
);
    import dmt_pkg::*;

    // Only one request is in flight, so the block is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while the previous one is in flight");

    // A result is never produced in the cycle right after a request is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

    // A new result only shows up while the input side was busy.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mex))
        else $error("stalled result changed");

endmodule

bind dynamic_mex_tracker dmt_checker u_dmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mex       (mex)
);
